@@ hdl/fsp_pkg.sv @@
// Package: types, character codes and helpers for the format spec parser.
package fsp_pkg;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [3:0] {
		PH_START  = 4'd0,
		PH_HELD   = 4'd1,
		PH_SIGN   = 4'd2,
		PH_PREFIX = 4'd3,
		PH_WIDTH  = 4'd4,
		PH_PREC   = 4'd5,
		PH_DONE   = 4'd6
	} fsp_phase_t;

	typedef enum logic [2:0] {
		K_BEGIN  = 3'd0,
		K_END    = 3'd1,
		K_ALIGN  = 3'd2,
		K_SIGN   = 3'd3,
		K_PREFIX = 3'd4,
		K_POINT  = 3'd5,
		K_NUMBER = 3'd6,
		K_TYPE   = 3'd7
	} fsp_kind_t;

	typedef struct packed {
		logic [7:0] fill_char;
		logic [7:0] align_char;
		logic [7:0] sign_char;
		logic [7:0] prefix_char;
		logic [7:0] field_width;
		logic [7:0] point_char;
		logic [7:0] precision;
		logic [7:0] type_char;
	} fsp_rec_t;

	typedef struct packed {
		fsp_phase_t phase;
		logic       held_valid;
		logic [7:0] held_char;
		fsp_rec_t   rec;
	} fsp_state_t;

	function automatic fsp_kind_t fsp_classify(input logic [7:0] c);
		fsp_kind_t k;
		if (c == CH_LBRACE) k = K_BEGIN;
		else if (c == CH_RBRACE) k = K_END;
		else if (c == CH_LT || c == CH_GT || c == CH_CARET || c == CH_EQ) k = K_ALIGN;
		else if (c == CH_PLUS || c == CH_MINUS) k = K_SIGN;
		else if (c == CH_HASH) k = K_PREFIX;
		else if (c == CH_POINT) k = K_POINT;
		else if (c >= CH_ZERO && c <= CH_NINE) k = K_NUMBER;
		else k = K_TYPE;
		return k;
	endfunction

	function automatic logic [7:0] fsp_add_digit(input logic [7:0] acc, input logic [7:0] c);
		logic [7:0] d;
		d = c - CH_ZERO;
		return {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + d;
	endfunction

endpackage

@@ hdl/format_spec_parser.sv @@
// Top level: format spec parser with input stage, parse state and result register.
// The last character passes the input stage, then loads the result register.
// Throughput: one character per cycle when not stalled; state updates in one step.
// A pending record stalls the input stage only when another last character waits.
// Reset (arst_n low, asynchronous) clears the parse state and both valid flags.
module format_spec_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] char_byte,
	input  logic       char_present,
	input  logic       last_char,
	output logic       rec_valid,
	input  logic       rec_ready,
	output logic [7:0] fill_char,
	output logic [7:0] align_char,
	output logic [7:0] sign_char,
	output logic [7:0] prefix_char,
	output logic [7:0] field_width,
	output logic [7:0] point_char,
	output logic [7:0] precision,
	output logic [7:0] type_char
);
	import fsp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       present_s1;
	logic       last_s1;
	logic       adv;
	fsp_state_t state_q;
	fsp_state_t state_nxt;
	fsp_rec_t   rec_nxt;
	fsp_rec_t   rec_q;
	logic       rec_valid_q;

	assign adv        = valid_s1 && (!last_s1 || !rec_valid_q || rec_ready);
	assign char_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			byte_s1    <= char_byte;
			present_s1 <= char_present;
			last_s1    <= last_char;
		end
	end

	fsp_step u_step (
		.cur          (state_q),
		.char_byte    (byte_s1),
		.char_present (present_s1),
		.last_char    (last_s1),
		.nxt          (state_nxt),
		.rec          (rec_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_START, held_valid: 1'b0, held_char: 8'h00, rec: '0};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			rec_valid_q <= 1'b1;
		end else if (rec_ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			rec_q <= rec_nxt;
		end
	end

	assign rec_valid   = rec_valid_q;
	assign fill_char   = rec_q.fill_char;
	assign align_char  = rec_q.align_char;
	assign sign_char   = rec_q.sign_char;
	assign prefix_char = rec_q.prefix_char;
	assign field_width = rec_q.field_width;
	assign point_char  = rec_q.point_char;
	assign precision   = rec_q.precision;
	assign type_char   = rec_q.type_char;

	a_last_loads_rec: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> rec_valid_q)
		else $error("record not loaded after last character");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> state_q.phase == PH_START && !state_q.held_valid)
		else $error("parse state not restarted after last character");

	a_held_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.held_valid == (state_q.phase == PH_HELD))
		else $error("held flag out of step with phase");

endmodule

@@ hdl/fsp_step.sv @@
// Next-state and record logic for one spec character.
module fsp_step (
	input  fsp_pkg::fsp_state_t cur,
	input  logic [7:0]          char_byte,
	input  logic                char_present,
	input  logic                last_char,
	output fsp_pkg::fsp_state_t nxt,
	output fsp_pkg::fsp_rec_t   rec
);
	import fsp_pkg::*;

	fsp_kind_t  kind;
	fsp_state_t upd;
	logic       fall_sign;
	logic       fall_prefix;
	logic       fall_width;

	assign kind        = fsp_classify(char_byte);
	assign fall_sign   = (cur.phase == PH_SIGN) ||
		((cur.phase == PH_START) && (kind != K_ALIGN) && (kind != K_TYPE));
	assign fall_prefix = (cur.phase == PH_PREFIX) || (fall_sign && (kind != K_SIGN));
	assign fall_width  = (cur.phase == PH_WIDTH) || (fall_prefix && (kind != K_PREFIX));

	always_comb begin
		upd = cur;
		if (char_present && (cur.phase != PH_DONE)) begin
			if (cur.phase == PH_HELD) begin
				if (kind == K_ALIGN) begin
					upd.rec.fill_char  = cur.held_char;
					upd.rec.align_char = char_byte;
					upd.phase          = PH_SIGN;
				end else begin
					upd.rec.type_char = cur.held_char;
					upd.phase         = PH_DONE;
				end
				upd.held_char  = '0;
				upd.held_valid = 1'b0;
			end else if (cur.phase == PH_START && kind == K_ALIGN) begin
				upd.rec.align_char = char_byte;
				upd.phase          = PH_SIGN;
			end else if (cur.phase == PH_START && kind == K_TYPE) begin
				upd.held_char  = char_byte;
				upd.held_valid = 1'b1;
				upd.phase      = PH_HELD;
			end else if (fall_sign && kind == K_SIGN) begin
				upd.rec.sign_char = char_byte;
				upd.phase         = PH_PREFIX;
			end else if (fall_prefix && kind == K_PREFIX) begin
				upd.rec.prefix_char = char_byte;
				upd.phase           = PH_WIDTH;
			end else if (fall_width && kind == K_NUMBER) begin
				upd.rec.field_width = fsp_add_digit(cur.rec.field_width, char_byte);
				upd.phase           = PH_WIDTH;
			end else if (fall_width && kind == K_POINT) begin
				upd.rec.point_char = char_byte;
				upd.phase          = PH_PREC;
			end else if (cur.phase == PH_PREC && kind == K_NUMBER) begin
				upd.rec.precision = fsp_add_digit(cur.rec.precision, char_byte);
			end else begin
				if (kind != K_END) upd.rec.type_char = char_byte;
				upd.phase = PH_DONE;
			end
		end
		// repair a held first character at end of spec
		if (last_char && upd.phase == PH_HELD && upd.held_valid) begin
			upd.rec.type_char = upd.held_char;
			upd.phase         = PH_DONE;
		end
	end

	always_comb begin
		rec = upd.rec;
		nxt = upd;
		if (last_char) begin
			nxt.phase      = PH_START;
			nxt.held_valid = 1'b0;
			nxt.held_char  = '0;
			nxt.rec        = '0;
		end
	end

endmodule
